// ----- hdl/app_pkg.sv -----
`timescale 1ns / 1ps

package app_pkg;

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = Q_W + FRAC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int W_W       = 17;

    // register indexes on the config channel
    localparam logic [7:0] REG_GAIN_P    = 8'd0;
    localparam logic [7:0] REG_GAIN_I    = 8'd1;
    localparam logic [7:0] REG_GAIN_D    = 8'd2;
    localparam logic [7:0] REG_FLOOR     = 8'd3;
    localparam logic [7:0] REG_CEILING   = 8'd4;
    localparam logic [7:0] REG_LOOKAHEAD = 8'd5;
    localparam logic [7:0] REG_BLEND     = 8'd6;
    localparam logic [7:0] REG_STEP_TIME = 8'd7;

    localparam logic [W_W-1:0] ONE_Q16 = 17'd65536;

    // zone and saturation scale factors, Q16
    localparam logic [W_W-1:0] FP_NEAR  = 17'd55705;
    localparam logic [W_W-1:0] FI_NEAR  = 17'd78643;
    localparam logic [W_W-1:0] FP_FAR   = 17'd81920;
    localparam logic [W_W-1:0] FI_FAR   = 17'd52428;
    localparam logic [W_W-1:0] FD_SAT   = 17'd49152;

    localparam logic [31:0] NEAR_LIMIT = 32'd131072;
    localparam logic [31:0] FAR_LIMIT  = 32'd655360;

    typedef enum logic [1:0] {
        ZONE_NORMAL = 2'd0,
        ZONE_NEAR   = 2'd1,
        ZONE_FAR    = 2'd2
    } zone_t;

    typedef struct packed {
        logic                    start;
        logic signed [Q_W-1:0]   num;
        logic signed [Q_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [Q_W-1:0]   quo;
    } div_rsp_t;

    // divide by 65536, truncated toward zero
    function automatic logic signed [63:0] q16_trunc(input logic signed [63:0] v);
        logic signed [63:0] q;
        q = v >>> FRAC_W;
        if (v[63] && (v[FRAC_W-1:0] != '0))
            q = q + 64'sd1;
        return q;
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] q;
        q = q16_trunc(v);
        if (q > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (q < -64'sh0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return q[Q_W-1:0];
    endfunction

endpackage

// ----- hdl/app_div.sv -----
`timescale 1ns / 1ps

module app_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  app_pkg::div_req_t req,
    output app_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic [app_pkg::CNT_W-1:0]       cnt_reg;
    logic [app_pkg::Q_W:0]           rem_reg;
    logic [app_pkg::DIV_STEPS-1:0]   nq_reg;
    logic [app_pkg::Q_W-1:0]         den_reg;
    logic                            neg_reg;
    logic                            done_reg;
    logic signed [app_pkg::Q_W-1:0]  quo_reg;

    logic [app_pkg::Q_W-1:0]         num_mag;
    logic [app_pkg::Q_W-1:0]         den_mag;
    logic [app_pkg::Q_W:0]           rem_shift;
    logic                            fits;
    logic [app_pkg::Q_W:0]           rem_next;
    logic [app_pkg::DIV_STEPS-1:0]   nq_next;

    assign num_mag   = req.num[app_pkg::Q_W-1] ? 32'(-req.num) : req.num;
    assign den_mag   = req.den[app_pkg::Q_W-1] ? 32'(-req.den) : req.den;
    assign rem_shift = {rem_reg[app_pkg::Q_W-1:0], nq_reg[app_pkg::DIV_STEPS-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_next  = fits ? rem_shift - {1'b0, den_reg} : rem_shift;
    assign nq_next   = {nq_reg[app_pkg::DIV_STEPS-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg <= '0;
                nq_reg  <= {num_mag, {app_pkg::FRAC_W{1'b0}}};
                den_reg <= den_mag;
                neg_reg <= req.num[app_pkg::Q_W-1] ^ req.den[app_pkg::Q_W-1];
                cnt_reg <= app_pkg::CNT_W'(app_pkg::DIV_STEPS - 1);
                if (req.den == '0)
                begin
                    quo_reg  <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                nq_reg  <= nq_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quo_reg  <= neg_reg ? 32'(-nq_next) : nq_next[app_pkg::Q_W-1:0];
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- hdl/adaptive_predictive_pid.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  target_value, measured_value
// m_*       out        m_tvalid / m_tready  drive_value
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// the rate divide (step_time above zero) and, when the integral term is
// clamped, the integral back-solve each run through the 48-step divider; a
// zero divisor gives a zero quotient.
// all multiplies go through one shared 33x33 multiplier, one product a cycle.
// reset clears controller state and loads register defaults; config is taken
// only while idle. a finished word is held in the output register; the next
// word can be taken meanwhile, and the step stalls at its end while the output
// is still full.

module adaptive_predictive_pid
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] target_value, [63:32] measured_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] drive_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_DIV1, S_MPRED, S_BL1, S_BL2, S_KP, S_KPW, S_PT,
        S_KI, S_KIW, S_IS, S_ISW, S_IT, S_CLAMP, S_DIV2, S_KD, S_KDW,
        S_DT, S_SUM, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] floor_reg, ceiling_reg, lookahead_reg, step_reg;
    logic [16:0]        blend_reg;

    logic signed [31:0] isum_reg, last_err_reg;
    app_pkg::zone_t     zone_reg;
    logic               sat_reg;

    logic signed [31:0] target_reg, measured_reg;
    logic signed [31:0] err_reg, rate_reg, pred_reg, eff_reg;
    logic signed [31:0] k_reg, ki_reg, pt_reg, it_reg, out_reg;
    logic signed [63:0] acc_reg, prod_reg;

    logic               m_tvalid_reg;
    logic signed [31:0] m_tdata_reg;

    logic signed [32:0] mul_a, mul_b;
    logic [16:0]        w_eff, fp, fi, fd;
    logic signed [31:0] prod_q16, it_now, sum_now, err_now;
    logic signed [63:0] blend_sum;
    logic [31:0]        mag;
    logic               out_free;

    app_pkg::div_req_t  div_req;
    app_pkg::div_rsp_t  div_rsp;

    app_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign w_eff    = (blend_reg > app_pkg::ONE_Q16) ? app_pkg::ONE_Q16 : blend_reg;
    assign prod_q16 = prod_reg[47:16];
    assign err_now  = target_reg - measured_reg;
    assign blend_sum = acc_reg + prod_reg;
    assign it_now   = prod_q16;
    assign sum_now  = pt_reg + (it_reg + prod_q16);
    assign mag      = err_reg[31] ? 32'(-err_reg) : err_reg;

    always_comb
    begin
        case (zone_reg)
            app_pkg::ZONE_NEAR:
            begin
                fp = app_pkg::FP_NEAR;
                fi = app_pkg::FI_NEAR;
            end
            app_pkg::ZONE_FAR:
            begin
                fp = app_pkg::FP_FAR;
                fi = app_pkg::FI_FAR;
            end
            default:
            begin
                fp = app_pkg::ONE_Q16;
                fi = app_pkg::ONE_Q16;
            end
        endcase
        fd = sat_reg ? app_pkg::FD_SAT : app_pkg::ONE_Q16;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MPRED:
            begin
                mul_a = {rate_reg[31], rate_reg};
                mul_b = {lookahead_reg[31], lookahead_reg};
            end
            S_BL1:
            begin
                mul_a = $signed({16'd0, 17'(app_pkg::ONE_Q16 - w_eff)});
                mul_b = {err_reg[31], err_reg};
            end
            S_BL2:
            begin
                mul_a = $signed({16'd0, w_eff});
                mul_b = {pred_reg[31], pred_reg};
            end
            S_KP:
            begin
                mul_a = {gain_p_reg[31], gain_p_reg};
                mul_b = $signed({16'd0, fp});
            end
            S_PT:
            begin
                mul_a = {k_reg[31], k_reg};
                mul_b = {eff_reg[31], eff_reg};
            end
            S_KI:
            begin
                mul_a = {gain_i_reg[31], gain_i_reg};
                mul_b = $signed({16'd0, fi});
            end
            S_IS:
            begin
                mul_a = {err_reg[31], err_reg};
                mul_b = {step_reg[31], step_reg};
            end
            S_IT:
            begin
                mul_a = {ki_reg[31], ki_reg};
                mul_b = {isum_reg[31], isum_reg};
            end
            S_KD:
            begin
                mul_a = {gain_d_reg[31], gain_d_reg};
                mul_b = $signed({16'd0, fd});
            end
            S_DT:
            begin
                mul_a = {k_reg[31], k_reg};
                mul_b = {rate_reg[31], rate_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = err_now - last_err_reg;
        div_req.den   = step_reg;
        if (state_reg == S_ERR)
        begin
            div_req.start = (step_reg > 32'sd0);
        end
        else if (state_reg == S_CLAMP)
        begin
            div_req.den = ki_reg;
            if (it_now > ceiling_reg)
            begin
                div_req.start = 1'b1;
                div_req.num   = ceiling_reg;
            end
            else if (it_now < floor_reg)
            begin
                div_req.start = 1'b1;
                div_req.num   = floor_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            floor_reg     <= 32'sh8000_0000;
            ceiling_reg   <= 32'sh7FFF_FFFF;
            lookahead_reg <= 32'sd65;
            blend_reg     <= 17'd32768;
            step_reg      <= 32'sd655;
            isum_reg      <= '0;
            last_err_reg  <= '0;
            zone_reg      <= app_pkg::ZONE_NORMAL;
            sat_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    app_pkg::REG_GAIN_P:
                    begin
                        gain_p_reg <= cfg_data;
                        isum_reg   <= '0;
                    end
                    app_pkg::REG_GAIN_I:
                    begin
                        gain_i_reg <= cfg_data;
                        isum_reg   <= '0;
                    end
                    app_pkg::REG_GAIN_D:
                    begin
                        gain_d_reg <= cfg_data;
                        isum_reg   <= '0;
                    end
                    app_pkg::REG_FLOOR:     floor_reg     <= cfg_data;
                    app_pkg::REG_CEILING:   ceiling_reg   <= cfg_data;
                    app_pkg::REG_LOOKAHEAD: lookahead_reg <= cfg_data;
                    app_pkg::REG_BLEND:     blend_reg     <= cfg_data[16:0];
                    app_pkg::REG_STEP_TIME: step_reg      <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        target_reg   <= s_tdata[31:0];
                        measured_reg <= s_tdata[63:32];
                        state_reg    <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg <= err_now;
                    if (step_reg > 32'sd0)
                        state_reg <= S_DIV1;
                    else
                    begin
                        rate_reg  <= '0;
                        state_reg <= S_MPRED;
                    end
                end
                S_DIV1:
                begin
                    if (div_rsp.done)
                    begin
                        rate_reg  <= div_rsp.quo;
                        state_reg <= S_MPRED;
                    end
                end
                S_MPRED: state_reg <= S_BL1;
                S_BL1:
                begin
                    pred_reg  <= err_reg + prod_q16;
                    state_reg <= S_BL2;
                end
                S_BL2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_KP;
                end
                S_KP:
                begin
                    eff_reg   <= 32'(app_pkg::q16_trunc(blend_sum));
                    state_reg <= S_KPW;
                end
                S_KPW:
                begin
                    k_reg     <= app_pkg::sat32(prod_reg);
                    state_reg <= S_PT;
                end
                S_PT:    state_reg <= S_KI;
                S_KI:
                begin
                    pt_reg    <= prod_q16;
                    state_reg <= S_KIW;
                end
                S_KIW:
                begin
                    ki_reg    <= app_pkg::sat32(prod_reg);
                    state_reg <= S_IS;
                end
                S_IS:    state_reg <= S_ISW;
                S_ISW:
                begin
                    isum_reg  <= isum_reg + prod_q16;
                    state_reg <= S_IT;
                end
                S_IT:    state_reg <= S_CLAMP;
                S_CLAMP:
                begin
                    if (it_now > ceiling_reg)
                    begin
                        it_reg    <= ceiling_reg;
                        state_reg <= S_DIV2;
                    end
                    else if (it_now < floor_reg)
                    begin
                        it_reg    <= floor_reg;
                        state_reg <= S_DIV2;
                    end
                    else
                    begin
                        it_reg    <= it_now;
                        state_reg <= S_KD;
                    end
                end
                S_DIV2:
                begin
                    if (div_rsp.done)
                    begin
                        isum_reg  <= div_rsp.quo;
                        state_reg <= S_KD;
                    end
                end
                S_KD:    state_reg <= S_KDW;
                S_KDW:
                begin
                    k_reg     <= app_pkg::sat32(prod_reg);
                    state_reg <= S_DT;
                end
                S_DT:    state_reg <= S_SUM;
                S_SUM:
                begin
                    // floor is tested before ceiling
                    if (sum_now < floor_reg)
                        out_reg <= floor_reg;
                    else if (sum_now > ceiling_reg)
                        out_reg <= ceiling_reg;
                    else
                        out_reg <= sum_now;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= out_reg;
                        last_err_reg <= err_reg;
                        if (mag < app_pkg::NEAR_LIMIT)
                            zone_reg <= app_pkg::ZONE_NEAR;
                        else if (mag > app_pkg::FAR_LIMIT)
                            zone_reg <= app_pkg::ZONE_FAR;
                        else
                            zone_reg <= app_pkg::ZONE_NORMAL;
                        sat_reg   <= (out_reg >= ceiling_reg) || (out_reg <= floor_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_ERR))
        else $error("accepted word did not start a step");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("divider finished outside a wait state");

    a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && floor_reg <= ceiling_reg)
            |-> (out_reg >= floor_reg && out_reg <= ceiling_reg))
        else $error("drive value outside limits");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("finished step did not present its word");
`endif

endmodule

// ----- tb/adaptive_predictive_pid_test.sv -----
`timescale 1ns / 1ps

module adaptive_predictive_pid_test;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    adaptive_predictive_pid dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // controller shadow state
    logic signed [31:0] kp_base, ki_base, kd_base, lo_lim, hi_lim, horizon, period;
    logic [16:0]        weight;
    logic signed [31:0] integ, prev_err;
    app_pkg::zone_t     zone;
    logic               sat_flag;

    logic [63:0] pending_words[$];
    logic [31:0] drive_expected[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;

    function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[47:16];
    endfunction

    function automatic logic signed [31:0] qdiv(logic signed [31:0] n, logic signed [31:0] d);
        logic signed [63:0] q;
        if (d == 0)
            return 0;
        q = (64'(n) * 64'sd65536) / 64'(d);
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] scaled(logic signed [31:0] k, int f);
        logic signed [63:0] v;
        v = (64'(k) * 64'(f)) / 64'sd65536;
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void set_register(logic [7:0] idx, logic [31:0] v);
        case (idx)
            app_pkg::REG_GAIN_P:    begin kp_base = v; integ = 0; end
            app_pkg::REG_GAIN_I:    begin ki_base = v; integ = 0; end
            app_pkg::REG_GAIN_D:    begin kd_base = v; integ = 0; end
            app_pkg::REG_FLOOR:     lo_lim = v;
            app_pkg::REG_CEILING:   hi_lim = v;
            app_pkg::REG_LOOKAHEAD: horizon = v;
            app_pkg::REG_BLEND:     weight = v[16:0];
            app_pkg::REG_STEP_TIME: period = v;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] control_step(logic [63:0] word);
        logic signed [31:0] err, rate, pred, eff, kp, ki, kd, pt, it, dt, o;
        logic signed [63:0] w, blend;
        int fp, fi, fd;
        logic [31:0] mag;
        err = word[31:0] - word[63:32];
        rate = period > 0 ? qdiv(err - prev_err, period) : 0;
        pred = err + qmul(rate, horizon);
        w = weight > 17'd65536 ? 64'sd65536 : 64'(weight);
        blend = ((64'sd65536 - w) * 64'(err) + w * 64'(pred)) / 64'sd65536;
        eff = blend[31:0];
        fp = 65536;
        fi = 65536;
        fd = sat_flag ? 49152 : 65536;
        if (zone == app_pkg::ZONE_NEAR)
        begin
            fp = 55705;
            fi = 78643;
        end
        else if (zone == app_pkg::ZONE_FAR)
        begin
            fp = 81920;
            fi = 52428;
        end
        kp = scaled(kp_base, fp);
        ki = scaled(ki_base, fi);
        kd = scaled(kd_base, fd);
        pt = qmul(kp, eff);
        integ = integ + qmul(err, period);
        it = qmul(ki, integ);
        if (it > hi_lim)
        begin
            it = hi_lim;
            integ = qdiv(hi_lim, ki);
        end
        else if (it < lo_lim)
        begin
            it = lo_lim;
            integ = qdiv(lo_lim, ki);
        end
        dt = qmul(kd, rate);
        o = pt + (it + dt);
        if (o < lo_lim)
            o = lo_lim;
        else if (o > hi_lim)
            o = hi_lim;
        prev_err = err;
        mag = err[31] ? 32'(-err) : err;
        if (mag < app_pkg::NEAR_LIMIT)
            zone = app_pkg::ZONE_NEAR;
        else if (mag > app_pkg::FAR_LIMIT)
            zone = app_pkg::ZONE_FAR;
        else
            zone = app_pkg::ZONE_NORMAL;
        sat_flag = (o >= hi_lim) || (o <= lo_lim);
        return o;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            drive_expected.push_back(control_step(s_tdata));
            void'(pending_words.pop_front());
        end
        if (!s_tvalid || s_tready)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (m_tvalid && m_tready)
        begin
            if (drive_expected.size() == 0)
            begin
                $display("%0t: unexpected drive_value, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = drive_expected.pop_front();
                if (want !== m_tdata)
                begin
                    $display("%0t: drive_value mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                    fail_count++;
                end
            end
        end
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_register(logic [7:0] idx, logic [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        set_register(idx, v);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_words.size() != 0 || s_tvalid || drive_expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q16(int sizing);
        case (sizing)
            0: return $urandom();
            1: return $urandom_range(1, 3) == 1 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 2 * 2000000)) - 2000000);
        endcase
    endfunction

    function automatic void queue_random(int count);
        logic [31:0] tgt;
        for (int n = 0; n < count; n++)
        begin
            tgt = rand_q16($urandom_range(9) == 0 ? 0 : 2);
            // mostly near the target so all zones are visited
            pending_words.push_back({32'(tgt - 32'($signed($urandom_range(0, 1600000)) - 800000)),
                                     tgt});
            if ($urandom_range(19) == 0)
                pending_words[$] = {$urandom(), $urandom()};
        end
    endfunction

    task automatic random_gains;
        logic signed [31:0] a, b;
        write_register(app_pkg::REG_GAIN_P, 32'($signed($urandom_range(0, 400000)) - 100000));
        write_register(app_pkg::REG_GAIN_I, 32'($signed($urandom_range(0, 200000)) - 50000));
        write_register(app_pkg::REG_GAIN_D, $urandom_range(3) == 0 ? $urandom()
                                            : 32'($urandom_range(0, 3000)));
        a = 32'($signed($urandom_range(0, 20000000)) - 10000000);
        b = 32'($signed($urandom_range(0, 20000000)) - 10000000);
        write_register(app_pkg::REG_FLOOR, a < b ? a : b);
        write_register(app_pkg::REG_CEILING, a < b ? b : a);
        write_register(app_pkg::REG_LOOKAHEAD, $urandom_range(3) == 0 ? $urandom()
                                               : 32'($urandom_range(0, 131072)));
        write_register(app_pkg::REG_BLEND, $urandom_range(0, 70000));
        write_register(app_pkg::REG_STEP_TIME, $urandom_range(7) == 0 ? $urandom()
                                               : 32'($urandom_range(1, 70000)));
    endtask

    initial
    begin
        kp_base = 0; ki_base = 0; kd_base = 0;
        lo_lim = 32'sh8000_0000; hi_lim = 32'sh7FFF_FFFF;
        horizon = 65; weight = 17'd32768; period = 655;
        integ = 0; prev_err = 0; zone = app_pkg::ZONE_NORMAL; sat_flag = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes at reset settings
        pending_words.push_back({32'h0000_0000, 32'h0000_0000});
        pending_words.push_back({32'h8000_0000, 32'h7FFF_FFFF});
        pending_words.push_back({32'h7FFF_FFFF, 32'h8000_0000});
        pending_words.push_back({32'h0000_0000, 32'h8000_0000});
        pending_words.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        drain();

        // large gains saturate the scaled gains, blend weight above one
        write_register(app_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
        write_register(app_pkg::REG_GAIN_I, 32'h8000_0000);
        write_register(app_pkg::REG_GAIN_D, 32'h7FFF_FFFF);
        write_register(app_pkg::REG_BLEND, 32'h0001_FFFF);
        write_register(app_pkg::REG_LOOKAHEAD, 32'h7FFF_FFFF);
        pending_words.push_back({32'h0000_0000, 32'h0000_1000});
        pending_words.push_back({32'h0100_0000, 32'h0000_0000});
        pending_words.push_back({32'h0000_0000, 32'h0000_0000});
        pending_words.push_back({32'h8000_0000, 32'h0000_0000});
        drain();

        // floor above ceiling, nonpositive step time, zero ki on clamp
        write_register(app_pkg::REG_FLOOR, 32'h0001_0000);
        write_register(app_pkg::REG_CEILING, 32'hFFFF_0000);
        write_register(app_pkg::REG_STEP_TIME, 32'h0000_0000);
        write_register(app_pkg::REG_GAIN_I, 32'h0000_0000);
        write_register(app_pkg::REG_BLEND, 32'h0000_0000);
        pending_words.push_back({32'h0003_0000, 32'h0000_0000});
        pending_words.push_back({32'h0000_0000, 32'h0003_0000});
        drain();
        write_register(app_pkg::REG_STEP_TIME, 32'h8000_0000);
        drain();
        write_register(app_pkg::REG_STEP_TIME, 32'h7FFF_FFFF);
        write_register(app_pkg::REG_GAIN_I, 32'h0001_0000);
        write_register(app_pkg::REG_FLOOR, 32'h0000_1000);
        write_register(app_pkg::REG_CEILING, 32'h0000_2000);
        pending_words.push_back({32'h0000_0000, 32'h0050_0000});
        pending_words.push_back({32'h0050_0000, 32'h0000_0000});
        pending_words.push_back({32'h0000_8000, 32'h0000_0000});
        drain();
        write_register(app_pkg::REG_BLEND, 32'h0001_0000);
        drain();

        // random phases with different idling mixes
        for (int phase = 0; phase < 12; phase++)
        begin
            send_idle_pct = phase < 4 ? 19 : (phase < 8 ? 88 : 0);
            recv_idle_pct = phase < 4 ? 88 : (phase < 8 ? 19 : 0);
            random_gains();
            queue_random(160);
            if (phase == 2)
            begin
                recv_hold = 1'b1;
                repeat (2000) @(posedge clk);
                recv_hold = 1'b0;
            end
            drain();
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/app_pkg.sv
hdl/app_div.sv
hdl/adaptive_predictive_pid.sv
tb/adaptive_predictive_pid_test.sv
